// ===== rtl/core/mwht_pkg.sv =====
package mwht_pkg;

   // fixed field widths
   localparam int ValueWidth = 30;
   localparam int IndexWidth = 6;
   localparam int CountWidth = 7;
   localparam int ModeWidth  = 2;
   localparam int HalfWidth  = 2;

   // defaults for the top level parameters
   localparam int unsigned DefaultMaxHalf = 3;
   localparam int unsigned DefaultPrime   = 1000000007;

   // transform modes
   localparam logic [ModeWidth-1:0] ModeForward = 2'd0;
   localparam logic [ModeWidth-1:0] ModeInverse = 2'd1;
   localparam logic [ModeWidth-1:0] ModeTwist   = 2'd2;

   // register indexes
   localparam logic CsrHalfDim = 1'b0;
   localparam logic CsrMode    = 1'b1;

   // kind of work handed from front to back
   typedef enum logic [1:0] {
      ITEM_LOAD,
      ITEM_RUN,
      ITEM_BAD
   } item_kind_type;

   typedef struct packed {
      item_kind_type             kind;
      logic [ValueWidth-1:0]     value;
      logic [IndexWidth-1:0]     index;
      logic [HalfWidth-1:0]      half;
      logic [ModeWidth-1:0]      mode;
   } work_item_type;

   // back end sequencer states
   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_BF_RD,
      ENG_BF_WA,
      ENG_BF_WB,
      ENG_SC_RD,
      ENG_SC_MUL,
      ENG_SC_WR,
      ENG_OUT_RD,
      ENG_OUT_LD,
      ENG_OUT_WAIT
   } eng_state_type;

endpackage

// ===== rtl/core/mwht_front.sv =====
module mwht_front #(
   parameter int unsigned MAX_HALF_DIMENSION = mwht_pkg::DefaultMaxHalf,
   parameter int unsigned PRIME_MODULUS      = mwht_pkg::DefaultPrime
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [mwht_pkg::ValueWidth-1:0]   residue,
   input  logic [mwht_pkg::HalfWidth-1:0]    half_cfg,
   input  logic [mwht_pkg::ModeWidth-1:0]    mode_cfg,
   input  logic                              q_full,
   output logic                              q_push,
   output mwht_pkg::work_item_type           q_item
);

   logic [mwht_pkg::CountWidth-1:0] load_count_ff, load_count_in;
   logic [mwht_pkg::CountWidth-1:0] count_plus;
   logic [mwht_pkg::CountWidth-1:0] size;
   logic [mwht_pkg::HalfWidth-1:0]  eff_half;
   logic [mwht_pkg::ModeWidth-1:0]  eff_mode;
   logic                            is_bad;
   logic                            completes;

   // effective half dimension and mode
   always_comb begin
      eff_half = half_cfg;
      if (half_cfg == '0) begin
         eff_half = mwht_pkg::HalfWidth'(1);
      end else if (32'(half_cfg) > MAX_HALF_DIMENSION) begin
         eff_half = mwht_pkg::HalfWidth'(MAX_HALF_DIMENSION);
      end
      eff_mode = (mode_cfg == mwht_pkg::ModeInverse || mode_cfg == mwht_pkg::ModeTwist)
                 ? mode_cfg : mwht_pkg::ModeForward;
   end

   // classify the incoming residue
   always_comb begin
      size       = mwht_pkg::CountWidth'(1) << {eff_half, 1'b0};
      count_plus = load_count_ff + mwht_pkg::CountWidth'(1);
      is_bad     = residue >= mwht_pkg::ValueWidth'(PRIME_MODULUS);
      completes  = count_plus >= size;
      full       = q_full;
      q_push     = push && !q_full;
      q_item.value = residue;
      q_item.index = load_count_ff[mwht_pkg::IndexWidth-1:0];
      q_item.half  = eff_half;
      q_item.mode  = eff_mode;
      if (is_bad) begin
         q_item.kind = mwht_pkg::ITEM_BAD;
      end else if (completes) begin
         q_item.kind = mwht_pkg::ITEM_RUN;
      end else begin
         q_item.kind = mwht_pkg::ITEM_LOAD;
      end
      load_count_in = load_count_ff;
      if (q_push) begin
         load_count_in = (is_bad || completes) ? '0 : count_plus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

endmodule

// ===== rtl/core/mwht_queue.sv =====
module mwht_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  mwht_pkg::work_item_type wr_item,
   output logic                    q_full,
   input  logic                    rd_en,
   output logic                    q_empty,
   output mwht_pkg::work_item_type rd_item
);

   mwht_pkg::work_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   // pointer and fill bookkeeping
   always_comb begin
      q_full    = count_ff == 2'd2;
      q_empty   = count_ff == 2'd0;
      do_wr     = wr_en && !q_full;
      do_rd     = rd_en && !q_empty;
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
      rd_item   = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ===== rtl/core/mwht_engine.sv =====
module mwht_engine #(
   parameter int unsigned MAX_HALF_DIMENSION = mwht_pkg::DefaultMaxHalf,
   parameter int unsigned PRIME_MODULUS      = mwht_pkg::DefaultPrime
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  mwht_pkg::work_item_type          q_item,
   output logic                             q_pop,
   output logic                             empty,
   input  logic                             pop,
   output logic [mwht_pkg::ValueWidth-1:0]  out_value,
   output logic [mwht_pkg::IndexWidth-1:0]  out_index,
   output logic                             last_flag,
   output logic                             bad_input
);

   localparam int AW    = 2 * MAX_HALF_DIMENSION;
   localparam int SW    = $clog2(2 * MAX_HALF_DIMENSION);
   localparam int VW    = mwht_pkg::ValueWidth;
   localparam int BW    = $clog2(VW);
   localparam int DEPTH = 1 << AW;

   // inverse of the batch size, worked out at elaboration
   function automatic logic [VW-1:0] inv_of_half(input int unsigned h);
      longint unsigned acc;
      longint unsigned base;
      longint unsigned e;
      acc  = 64'd1 % PRIME_MODULUS;
      base = (64'd1 << (2 * h)) % PRIME_MODULUS;
      e    = PRIME_MODULUS - 2;
      while (e != 0) begin
         if (e[0]) begin
            acc = (acc * base) % PRIME_MODULUS;
         end
         base = (base * base) % PRIME_MODULUS;
         e    = e >> 1;
      end
      return acc[VW-1:0];
   endfunction

   localparam logic [VW-1:0] Inv1 = inv_of_half(1);
   localparam logic [VW-1:0] Inv2 = inv_of_half(2);
   localparam logic [VW-1:0] Inv3 = inv_of_half(3);
   localparam logic [VW:0]   Prime = (VW+1)'(PRIME_MODULUS);

   mwht_pkg::eng_state_type state_ff, state_in;

   logic [VW-1:0]                 mem [DEPTH];
   logic [VW-1:0]                 rda_ff, rdb_ff;
   logic [VW-1:0]                 diff_ff, diff_in;
   logic [VW-1:0]                 acc_ff, acc_in;
   logic [BW-1:0]                 bit_ff, bit_in;
   logic [AW-1:0]                 cnt_ff, cnt_in;
   logic [SW-1:0]                 stage_ff, stage_in;
   logic [mwht_pkg::HalfWidth-1:0] half_ff, half_in;
   logic [mwht_pkg::ModeWidth-1:0] mode_ff, mode_in;
   logic                          second_ff, second_in;
   logic                          valid_ff, valid_in;
   logic [VW-1:0]                 val_ff, val_in;
   logic [mwht_pkg::IndexWidth-1:0] idx_ff, idx_in;
   logic                          last_ff, last_in;
   logic                          bad_ff, bad_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [VW-1:0] mem_wdata;
   logic [AW-1:0] rd_addr_a, bf_i, bf_j, size_mask, low_mask;
   logic [SW-1:0] stage_last;
   logic [VW-1:0] inv_sel, sum_v, diff_v, step_v, twist_v;
   logic [VW:0]   wide_sum, dbl, dbl_red, add_v;
   logic          par;
   logic          scaled;

   // batch geometry
   always_comb begin
      size_mask  = ~({AW{1'b1}} << {half_ff, 1'b0});
      stage_last = SW'({1'b0, half_ff, 1'b0} - 4'd1);
      low_mask   = (AW'(1) << stage_ff) - AW'(1);
      bf_i       = ((cnt_ff >> stage_ff) << (stage_ff + 1'b1)) | (cnt_ff & low_mask);
      bf_j       = bf_i | (AW'(1) << stage_ff);
      rd_addr_a  = (state_ff == mwht_pkg::ENG_BF_RD) ? bf_i : cnt_ff;
      scaled     = mode_ff == mwht_pkg::ModeInverse || mode_ff == mwht_pkg::ModeTwist;
   end

   // butterfly add and subtract mod p
   always_comb begin
      wide_sum = {1'b0, rda_ff} + {1'b0, rdb_ff};
      sum_v    = (wide_sum >= Prime) ? VW'(wide_sum - Prime) : wide_sum[VW-1:0];
      diff_v   = (rda_ff >= rdb_ff) ? (rda_ff - rdb_ff)
                                    : VW'({1'b0, rda_ff} + Prime - {1'b0, rdb_ff});
   end

   // one bit of the shift-add modular multiply
   always_comb begin
      case (half_ff)
         2'd1:    inv_sel = Inv1;
         2'd2:    inv_sel = Inv2;
         default: inv_sel = Inv3;
      endcase
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= Prime) ? dbl - Prime : dbl;
      add_v   = dbl_red + {1'b0, rda_ff};
      if (inv_sel[bit_ff]) begin
         step_v = (add_v >= Prime) ? VW'(add_v - Prime) : add_v[VW-1:0];
      end else begin
         step_v = dbl_red[VW-1:0];
      end
   end

   // sign twist on the scaled entry
   always_comb begin
      par = 1'b0;
      for (int k = 0; k < MAX_HALF_DIMENSION; k++) begin
         par ^= cnt_ff[2*k] & cnt_ff[2*k+1];
      end
      twist_v = acc_ff;
      if (mode_ff == mwht_pkg::ModeTwist && par && acc_ff != '0) begin
         twist_v = VW'(Prime - {1'b0, acc_ff});
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      stage_in  = stage_ff;
      half_in   = half_ff;
      mode_in   = mode_ff;
      second_in = second_ff;
      diff_in   = diff_ff;
      acc_in    = acc_ff;
      bit_in    = bit_ff;
      valid_in  = valid_ff;
      val_in    = val_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      bad_in    = bad_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = acc_ff;
      unique case (state_ff)
         mwht_pkg::ENG_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_item.kind)
                  mwht_pkg::ITEM_BAD: begin
                     valid_in = 1'b1;
                     val_in   = '0;
                     idx_in   = '0;
                     last_in  = 1'b1;
                     bad_in   = 1'b1;
                     state_in = mwht_pkg::ENG_OUT_WAIT;
                  end
                  mwht_pkg::ITEM_RUN: begin
                     mem_we    = 1'b1;
                     mem_waddr = q_item.index[AW-1:0];
                     mem_wdata = q_item.value;
                     half_in   = q_item.half;
                     mode_in   = q_item.mode;
                     second_in = 1'b0;
                     cnt_in    = '0;
                     stage_in  = '0;
                     state_in  = mwht_pkg::ENG_BF_RD;
                  end
                  default: begin
                     mem_we    = 1'b1;
                     mem_waddr = q_item.index[AW-1:0];
                     mem_wdata = q_item.value;
                  end
               endcase
            end
         end
         mwht_pkg::ENG_BF_RD: begin
            state_in = mwht_pkg::ENG_BF_WA;
         end
         mwht_pkg::ENG_BF_WA: begin
            mem_we    = 1'b1;
            mem_waddr = bf_i;
            mem_wdata = sum_v;
            diff_in   = diff_v;
            state_in  = mwht_pkg::ENG_BF_WB;
         end
         mwht_pkg::ENG_BF_WB: begin
            mem_we    = 1'b1;
            mem_waddr = bf_j;
            mem_wdata = diff_ff;
            state_in  = mwht_pkg::ENG_BF_RD;
            cnt_in    = cnt_ff + AW'(1);
            if (cnt_ff == (size_mask >> 1)) begin
               cnt_in = '0;
               if (stage_ff == stage_last) begin
                  stage_in = '0;
                  state_in = (scaled && !second_ff) ? mwht_pkg::ENG_SC_RD
                                                    : mwht_pkg::ENG_OUT_RD;
               end else begin
                  stage_in = stage_ff + SW'(1);
               end
            end
         end
         mwht_pkg::ENG_SC_RD: begin
            acc_in   = '0;
            bit_in   = BW'(VW - 1);
            state_in = mwht_pkg::ENG_SC_MUL;
         end
         mwht_pkg::ENG_SC_MUL: begin
            acc_in = step_v;
            if (bit_ff == '0) begin
               state_in = mwht_pkg::ENG_SC_WR;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end
         mwht_pkg::ENG_SC_WR: begin
            mem_we    = 1'b1;
            mem_wdata = twist_v;
            cnt_in    = cnt_ff + AW'(1);
            state_in  = mwht_pkg::ENG_SC_RD;
            if (cnt_ff == size_mask) begin
               cnt_in = '0;
               if (mode_ff == mwht_pkg::ModeTwist) begin
                  second_in = 1'b1;
                  state_in  = mwht_pkg::ENG_BF_RD;
               end else begin
                  state_in = mwht_pkg::ENG_OUT_RD;
               end
            end
         end
         mwht_pkg::ENG_OUT_RD: begin
            state_in = mwht_pkg::ENG_OUT_LD;
         end
         mwht_pkg::ENG_OUT_LD: begin
            valid_in = 1'b1;
            val_in   = rda_ff;
            idx_in   = mwht_pkg::IndexWidth'(cnt_ff);
            last_in  = cnt_ff == size_mask;
            bad_in   = 1'b0;
            state_in = mwht_pkg::ENG_OUT_WAIT;
         end
         mwht_pkg::ENG_OUT_WAIT: begin
            if (pop) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  state_in = mwht_pkg::ENG_IDLE;
               end else begin
                  cnt_in   = cnt_ff + AW'(1);
                  state_in = mwht_pkg::ENG_OUT_RD;
               end
            end
         end
         default: begin
            state_in = mwht_pkg::ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwht_pkg::ENG_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      stage_ff  <= stage_in;
      half_ff   <= half_in;
      mode_ff   <= mode_in;
      second_ff <= second_in;
      diff_ff   <= diff_in;
      acc_ff    <= acc_in;
      bit_ff    <= bit_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      bad_ff    <= bad_in;
   end

   // entry store, one write and two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rda_ff <= mem[rd_addr_a];
      rdb_ff <= mem[bf_j];
   end

   assign empty     = !valid_ff;
   assign out_value = val_ff;
   assign out_index = idx_ff;
   assign last_flag = last_ff;
   assign bad_input = bad_ff;

`ifndef ASSERT_OFF
   // an error result is always a lone zero result that ends the run
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && bad_ff) |-> (last_ff && val_ff == '0 && idx_ff == '0))
      else $error("error result not marked last");

   // the last normal result carries the top index of the batch
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff && !bad_ff) |-> (idx_ff == mwht_pkg::IndexWidth'(size_mask)))
      else $error("last mark on wrong index");

   // a butterfly write always follows its read
   a_bf_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwht_pkg::ENG_BF_WA) |-> ($past(state_ff) == mwht_pkg::ENG_BF_RD))
      else $error("butterfly write without read");

   // work is taken from the queue only while no run is in flight
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == mwht_pkg::ENG_IDLE && !valid_ff))
      else $error("queue popped while busy");
`endif

endmodule

// ===== rtl/core/modular_walsh_hadamard_transform.sv =====
// Walsh-Hadamard transform modulo a prime over a batch of 4^H residues, H
// from csr register half_dimension (0 reads as 1, large values saturate).
// Residues are pushed lowest index first; a front stage checks each against
// the modulus and tags it as a load, a batch-completing load or an error,
// and a two-entry queue hands the work to the back end. Loads that do not
// complete a batch produce no result. When a batch completes, the back end
// runs the butterflies one at a time through a single entry store with two
// read ports and one write port, each butterfly in a read, a first write and
// a second write state, (4^H / 2) * 2H butterflies per pass. The inverse and
// twist modes add a scaling pass over every entry (bit-serial multiply by the
// precomputed inverse of the size, with the sign twist folded in), and the
// twist mode adds a second butterfly pass. Results then leave one at a time,
// each held until popped, with its index and a last mark on the final one.
// A residue at or above the modulus gives a single error result (value and
// index zero, last and bad_input set) and drops the batch being loaded.
module modular_walsh_hadamard_transform #(
   parameter int unsigned MAX_HALF_DIMENSION = mwht_pkg::DefaultMaxHalf,
   parameter int unsigned PRIME_MODULUS      = mwht_pkg::DefaultPrime
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [mwht_pkg::ValueWidth-1:0]     req_residue,
   output logic                                empty,
   input  logic                                pop,
   output logic [mwht_pkg::ValueWidth-1:0]     rsp_out_value,
   output logic [mwht_pkg::IndexWidth-1:0]     rsp_out_index,
   output logic                                rsp_last_flag,
   output logic                                rsp_bad_input,
   input  logic                                csr_wr_en,
   input  logic                                csr_index,
   input  logic [mwht_pkg::ModeWidth-1:0]      csr_wdata
);

   logic [mwht_pkg::HalfWidth-1:0] half_dim_ff, half_dim_in;
   logic [mwht_pkg::ModeWidth-1:0] mode_ff, mode_in;

   mwht_pkg::work_item_type push_item, head_item;
   logic q_push, q_full, q_pop, q_empty;

   // configuration registers
   always_comb begin
      half_dim_in = half_dim_ff;
      mode_in     = mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mwht_pkg::CsrHalfDim: half_dim_in = csr_wdata;
            default:              mode_in     = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_dim_ff <= mwht_pkg::HalfWidth'(1);
         mode_ff     <= mwht_pkg::ModeForward;
      end else begin
         half_dim_ff <= half_dim_in;
         mode_ff     <= mode_in;
      end
   end

   mwht_front #(
      .MAX_HALF_DIMENSION (MAX_HALF_DIMENSION),
      .PRIME_MODULUS      (PRIME_MODULUS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .residue  (req_residue),
      .half_cfg (half_dim_ff),
      .mode_cfg (mode_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   mwht_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (push_item),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .q_empty (q_empty),
      .rd_item (head_item)
   );

   mwht_engine #(
      .MAX_HALF_DIMENSION (MAX_HALF_DIMENSION),
      .PRIME_MODULUS      (PRIME_MODULUS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (head_item),
      .q_pop     (q_pop),
      .empty     (empty),
      .pop       (pop),
      .out_value (rsp_out_value),
      .out_index (rsp_out_index),
      .last_flag (rsp_last_flag),
      .bad_input (rsp_bad_input)
   );

endmodule

// ===== tb/sv/mwht_checker.sv =====
module mwht_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic                              full,
   input  logic [mwht_pkg::ValueWidth-1:0]   req_residue,
   input  logic                              empty,
   input  logic                              pop,
   input  logic [mwht_pkg::ValueWidth-1:0]   rsp_out_value,
   input  logic [mwht_pkg::IndexWidth-1:0]   rsp_out_index,
   input  logic                              rsp_last_flag,
   input  logic                              rsp_bad_input,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [mwht_pkg::ModeWidth-1:0]    csr_wdata,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import mwht_pkg::*;

   localparam longint unsigned Prime = DefaultPrime;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic [IndexWidth-1:0] index;
      logic                  last;
      logic                  bad;
   } entry_result_type;

   // shadow copy of the block state
   logic [HalfWidth-1:0] half_reg;
   logic [ModeWidth-1:0] mode_reg;
   longint unsigned      coeff [64];
   int unsigned          loaded;
   entry_result_type     expected_entries [$];

   function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b);
      return (a * b) % Prime;
   endfunction

   function automatic longint unsigned size_inverse(longint unsigned n);
      longint unsigned acc, base, e;
      acc = 1; base = n % Prime; e = Prime - 2;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, base);
         base = mod_mul(base, base);
         e = e >> 1;
      end
      return acc;
   endfunction

   // in-place butterfly pass over the shadow store, optionally scaled
   task automatic hadamard_pass(int unsigned n, bit scaled);
      longint unsigned a, b, inv;
      for (int unsigned len = 1; len < n; len = len * 2)
         for (int unsigned bs = 0; bs < n; bs += 2 * len)
            for (int unsigned k = 0; k < len; k++) begin
               a = coeff[bs + k];
               b = coeff[bs + k + len];
               coeff[bs + k] = (a + b >= Prime) ? a + b - Prime : a + b;
               coeff[bs + k + len] = (a >= b) ? a - b : a + Prime - b;
            end
      if (scaled) begin
         inv = size_inverse(n);
         for (int unsigned k = 0; k < n; k++) coeff[k] = mod_mul(coeff[k], inv);
      end
   endtask

   // one accepted residue: update shadow state, queue resulting entries
   task automatic predict_residue(logic [ValueWidth-1:0] r);
      int unsigned h, n, par;
      entry_result_type e;
      h = (half_reg == 0) ? 1 : int'(half_reg);
      if (h > DefaultMaxHalf) h = DefaultMaxHalf;
      n = 1 << (2 * h);
      if (r >= Prime) begin
         loaded = 0;
         e = '{value: '0, index: '0, last: 1'b1, bad: 1'b1};
         expected_entries.insert(expected_entries.size(), e);
         return;
      end
      coeff[loaded % 64] = 64'(r);
      loaded = (loaded + 1) % 128;
      if (loaded < n) return;
      loaded = 0;
      if (mode_reg == ModeInverse) begin
         hadamard_pass(n, 1'b1);
      end else if (mode_reg == ModeTwist) begin
         hadamard_pass(n, 1'b1);
         for (int unsigned i = 0; i < n; i++) begin
            par = 0;
            for (int unsigned k = 0; k < h; k++) par ^= ((i >> (2 * k)) & (i >> (2 * k + 1))) & 1;
            if (par != 0 && coeff[i] != 0) coeff[i] = Prime - coeff[i];
         end
         hadamard_pass(n, 1'b0);
      end else begin
         hadamard_pass(n, 1'b0);
      end
      for (int unsigned i = 0; i < n; i++) begin
         e.value = coeff[i][ValueWidth-1:0];
         e.index = i[IndexWidth-1:0];
         e.last  = (i + 1 == n);
         e.bad   = 1'b0;
         expected_entries.insert(expected_entries.size(), e);
      end
   endtask

   // watch all three ports at each rising edge
   always @(posedge clock) begin
      entry_result_type exp_e;
      if (reset) begin
         half_reg = HalfWidth'(1);
         mode_reg = ModeForward;
         loaded = 0;
         expected_entries.delete();
         fail_count = 0;
      end else begin
         if (!empty && pop) begin
            if (expected_entries.size() == 0) begin
               $error("unexpected result transfer: value %0d index %0d", rsp_out_value,
                      rsp_out_index);
               fail_count++;
            end else begin
               exp_e = expected_entries.pop_front();
               if (rsp_out_value !== exp_e.value) begin
                  $error("out_value: expected %0d actual %0d", exp_e.value, rsp_out_value);
                  fail_count++;
               end
               if (rsp_out_index !== exp_e.index) begin
                  $error("out_index: expected %0d actual %0d", exp_e.index, rsp_out_index);
                  fail_count++;
               end
               if (rsp_last_flag !== exp_e.last) begin
                  $error("last_flag: expected %0d actual %0d", exp_e.last, rsp_last_flag);
                  fail_count++;
               end
               if (rsp_bad_input !== exp_e.bad) begin
                  $error("bad_input: expected %0d actual %0d", exp_e.bad, rsp_bad_input);
                  fail_count++;
               end
            end
         end
         if (push && !full) predict_residue(req_residue);
         if (csr_wr_en) begin
            if (csr_index == CsrHalfDim) half_reg = csr_wdata;
            else mode_reg = csr_wdata;
         end
      end
      pending = expected_entries.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule

// ===== tb/sv/tb_modular_walsh_hadamard_transform.sv =====
module tb_modular_walsh_hadamard_transform;
   timeunit 1ns;
   timeprecision 1ps;
   import mwht_pkg::*;

   localparam int unsigned Prime = DefaultPrime;
   localparam int CycleLimit = 600000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [ValueWidth-1:0] req_residue = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [ValueWidth-1:0] rsp_out_value;
   logic [IndexWidth-1:0] rsp_out_index;
   logic                  rsp_last_flag;
   logic                  rsp_bad_input;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_index = CsrHalfDim;
   logic [ModeWidth-1:0]  csr_wdata = '0;
   int                    fail_count;
   int                    pending;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 1'b0;
   int cycle_count = 0;
   int sent = 0;
   int half_now = 1;

   modular_walsh_hadamard_transform DUT (.*);

   mwht_checker u_checker (.*);

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("modular_walsh_hadamard_transform regression: fail");
         $finish;
      end
   end

   // receiver: random pop, with a long hold-off on request
   always @(negedge clock) begin
      int hold_left;
      if (hold_request && hold_left == 0) hold_left = 4000;
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(negedge clock) if (hold_request && !pop) hold_request <= 1'b0;

   // offer one residue until it transfers; ends at a falling edge with push held
   task automatic send_residue(logic [ValueWidth-1:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_residue <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // drain all results and let trailing loads settle
   task automatic wait_idle();
      push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [ModeWidth-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CsrHalfDim) half_now = (val == 0) ? 1 : int'(val);
   endtask

   function automatic logic [ValueWidth-1:0] good_residue();
      case ($urandom_range(9))
         0: return '0;
         1: return ValueWidth'(Prime - 1);
         default: return ValueWidth'($urandom_range(Prime - 1));
      endcase
   endfunction

   function automatic logic [ValueWidth-1:0] bad_residue();
      return ($urandom_range(1) == 0) ? ValueWidth'(Prime)
                                      : ValueWidth'($urandom_range(30'h3fffffff, Prime));
   endfunction

   task automatic send_batch(int bad_pct);
      for (int i = 0; i < (1 << (2 * half_now)); i++)
         send_residue(($urandom_range(99) < bad_pct) ? bad_residue() : good_residue());
   endtask

   initial begin
      logic [ModeWidth-1:0] h_pick;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes in forward mode, size four
      send_residue('0);
      send_residue(ValueWidth'(Prime - 1));
      send_residue(30'h2aaaaaaa);
      send_residue(30'h15555555);
      // bad residue mid-batch, including the all-ones word
      send_residue(ValueWidth'(Prime - 1));
      send_residue(30'h3fffffff);
      send_residue(ValueWidth'(Prime));
      wait_idle();
      // each mode, including the unused code, with half dimension zero
      write_csr(CsrHalfDim, 2'd0);
      write_csr(CsrMode, ModeInverse);
      send_batch(0);
      wait_idle();
      write_csr(CsrMode, ModeTwist);
      send_batch(0);
      wait_idle();
      write_csr(CsrMode, 2'd3);
      send_batch(0);
      wait_idle();
      // setting change mid-batch: five loads at size 64, then size 4
      write_csr(CsrHalfDim, 2'd3);
      write_csr(CsrMode, ModeTwist);
      repeat (5) send_residue(good_residue());
      wait_idle();
      write_csr(CsrHalfDim, 2'd1);
      send_residue(good_residue());
      wait_idle();

      // random phases with changing idle mix
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 56 : 0;
         recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 33 : 0;
         // largest size under a long receiver hold-off
         wait_idle();
         write_csr(CsrHalfDim, 2'd3);
         write_csr(CsrMode, phase[1:0]);
         hold_request <= 1'b1;
         send_batch(0);
         while (sent < 25 + 145 * (phase + 1)) begin
            if ($urandom_range(2) == 0) begin
               wait_idle();
               h_pick = ($urandom_range(7) == 0) ? 2'd3 : ModeWidth'($urandom_range(2));
               write_csr(CsrHalfDim, h_pick);
               write_csr(CsrMode, ModeWidth'($urandom_range(3)));
            end
            if ($urandom_range(9) == 0) begin
               // noise: short run of residues, each bad or good at even odds
               repeat ($urandom_range(3, 1)) send_residue(
                  ($urandom_range(1) == 0) ? bad_residue() : good_residue());
            end else begin
               send_batch(3);
            end
         end
      end

      wait_idle();
      repeat (200) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("modular_walsh_hadamard_transform regression: pass");
      end else begin
         $display("modular_walsh_hadamard_transform regression: fail");
      end
      $finish;
   end
endmodule
